[hw/rtl/jsu_pkg.sv]
// Package for the JSON string unescaper: codes, character constants, result bundle, helpers.
package jsu_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_WAIT    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_LOW_BSL = 3'd4,
    MODE_LOW_U   = 3'd5,
    MODE_LOW_HEX = 3'd6
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_QUOTE  = 3'd1,
    ERR_BAD_ESC   = 3'd2,
    ERR_BAD_HEX   = 3'd3,
    ERR_NO_LOW    = 3'd4,
    ERR_BAD_LOW   = 3'd5,
    ERR_EARLY_END = 3'd6
  } err_e;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Bytes that the simple escapes stand for
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // Surrogate ranges
  localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
  localparam logic [10:0] SUPP_BASE   = 11'h040;  // 0x10000 >> 10

  // One to four result words caused by one input word
  typedef struct packed {
    kind_e           kind;
    err_e            err;
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } bundle_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } utf8_t;

  // Hex digit value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

  // UTF-8 encoding of a code point, first byte in slot 0
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h00007F) begin
      r.bytes[0] = cp[7:0];
      r.count    = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      r.count    = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      r.count    = 3'd3;
    end else begin
      r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      r.count    = 3'd4;
    end
    return r;
  endfunction

endpackage

[hw/rtl/jsu_if.sv]
// Stream interfaces for the unescaper's input and result channels.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

[hw/rtl/json_string_unescape_utf8_unit.sv]
// Top level of the JSON string unescaper producing UTF-8.
//
//  channel  dir  word fields                              accepted when
//  in_i     in   in_byte[8], end_of_input[1]              valid && ready
//  out_o    out  kind[2], out_byte[8], error_code[3],     valid && ready
//                last[1]
//
// One input word is taken per cycle unless stalled; its results land in a result register
// the next cycle and leave one word per cycle through the output serialiser while out_o
// is ready. A word with several results holds the output until its last word is taken,
// so with out_o ready input runs at one word per cycle while each yields at most one
// result. The result register lets one more input word in while the serialiser waits.
// Reset puts the parser back to waiting for a quote and empties both stages.
module json_string_unescape_utf8_unit (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  logic    res_valid, res_ready;
  bundle_t res;

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  jsu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

[hw/rtl/jsu_decode.sv]
// Parser state machine and result register: one input word decoded per cycle while in_i.ready is high.
module jsu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  jsu_in_if.sink            in_i,
  output logic              res_valid_o,
  output jsu_pkg::bundle_t  res_o,
  input  logic              res_ready_i
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] hex_acc_q, hex_acc_d;
  logic [9:0]  high_q, high_d;
  logic        res_valid_q, res_valid_d;
  bundle_t     res_q, res_d;

  logic        accept;
  logic [4:0]  digit;
  logic [15:0] acc_next;
  logic [20:0] supp_cp;
  utf8_t       bmp_enc, supp_enc;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !res_valid_q || res_ready_i;

  // Hex gathering and the two encodings a completed escape can take
  assign digit    = hex_value(in_i.in_byte);
  assign acc_next = {hex_acc_q[11:0], digit[3:0]};
  assign supp_cp  = {(11'(high_q) + SUPP_BASE), acc_next[9:0]};
  assign bmp_enc  = utf8_encode({5'b00000, acc_next});
  assign supp_enc = utf8_encode(supp_cp);

  // Next state and the result bundle of the current word
  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    hex_acc_d = hex_acc_q;
    high_d    = high_q;
    res_d     = '{kind: KIND_DATA, err: ERR_NONE, bytes: '0, count: 3'd0};

    if (in_i.end_of_input) begin
      if (mode_q != MODE_WAIT) begin
        res_d.kind  = KIND_ERROR;
        res_d.err   = ERR_EARLY_END;
        res_d.count = 3'd1;
      end
    end else begin
      unique case (mode_q)
        MODE_STR: begin
          if (in_i.in_byte == CH_QUOTE) begin
            res_d.kind  = KIND_CLOSED;
            res_d.count = 3'd1;
            mode_d      = MODE_WAIT;
          end else if (in_i.in_byte == CH_BSL) begin
            mode_d = MODE_ESC;
          end else begin
            res_d.bytes[0] = in_i.in_byte;
            res_d.count    = 3'd1;
          end
        end

        MODE_ESC: begin
          res_d.count = 3'd1;
          mode_d      = MODE_STR;
          unique case (in_i.in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: res_d.bytes[0] = in_i.in_byte;
            CH_B: res_d.bytes[0] = BYTE_BS;
            CH_F: res_d.bytes[0] = BYTE_FF;
            CH_N: res_d.bytes[0] = BYTE_LF;
            CH_R: res_d.bytes[0] = BYTE_CR;
            CH_T: res_d.bytes[0] = BYTE_HT;
            CH_U: begin
              res_d.count = 3'd0;
              mode_d      = MODE_HEX;
              hex_cnt_d   = 2'd0;
              hex_acc_d   = 16'h0000;
            end
            default: begin
              res_d.kind = KIND_ERROR;
              res_d.err  = ERR_BAD_ESC;
            end
          endcase
        end

        MODE_HEX, MODE_LOW_HEX: begin
          if (digit[4]) begin
            res_d.kind  = KIND_ERROR;
            res_d.err   = ERR_BAD_HEX;
            res_d.count = 3'd1;
          end else if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
            hex_acc_d = acc_next;
          end else begin
            hex_cnt_d = 2'd0;
            hex_acc_d = 16'h0000;
            if (mode_q == MODE_HEX) begin
              if (acc_next >= HIGH_SUR_LO && acc_next <= HIGH_SUR_HI) begin
                high_d = acc_next[9:0];
                mode_d = MODE_LOW_BSL;
              end else begin
                res_d.bytes = bmp_enc.bytes;
                res_d.count = bmp_enc.count;
                mode_d      = MODE_STR;
              end
            end else if (acc_next < LOW_SUR_LO || acc_next > LOW_SUR_HI) begin
              res_d.kind  = KIND_ERROR;
              res_d.err   = ERR_BAD_LOW;
              res_d.count = 3'd1;
            end else begin
              res_d.bytes = supp_enc.bytes;
              res_d.count = supp_enc.count;
              high_d      = 10'd0;
              mode_d      = MODE_STR;
            end
          end
        end

        MODE_LOW_BSL: begin
          if (in_i.in_byte == CH_BSL) begin
            mode_d = MODE_LOW_U;
          end else begin
            res_d.kind  = KIND_ERROR;
            res_d.err   = ERR_NO_LOW;
            res_d.count = 3'd1;
          end
        end

        MODE_LOW_U: begin
          if (in_i.in_byte == CH_U) begin
            mode_d    = MODE_LOW_HEX;
            hex_cnt_d = 2'd0;
            hex_acc_d = 16'h0000;
          end else begin
            res_d.kind  = KIND_ERROR;
            res_d.err   = ERR_NO_LOW;
            res_d.count = 3'd1;
          end
        end

        default: begin
          // waiting for the opening quote
          if (in_i.in_byte == CH_QUOTE) begin
            mode_d = MODE_STR;
          end else begin
            res_d.kind  = KIND_ERROR;
            res_d.err   = ERR_NO_QUOTE;
            res_d.count = 3'd1;
          end
        end
      endcase
    end

    // any error sends all state back to its reset values
    if (res_d.kind == KIND_ERROR) begin
      mode_d    = MODE_WAIT;
      hex_cnt_d = 2'd0;
      hex_acc_d = 16'h0000;
      high_d    = 10'd0;
    end
  end

  // Result register occupancy
  always_comb begin
    res_valid_d = res_valid_q && !res_ready_i;
    if (accept) res_valid_d = (res_d.count != 3'd0);
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WAIT;
      hex_cnt_q   <= 2'd0;
      hex_acc_q   <= 16'h0000;
      high_q      <= 10'd0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (accept) begin
        mode_q    <= mode_d;
        hex_cnt_q <= hex_cnt_d;
        hex_acc_q <= hex_acc_d;
        high_q    <= high_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && res_d.count != 3'd0) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/jsu_emit.sv]
// Output serialiser: sends the words of one result bundle one per cycle while out_o.ready is high.
module jsu_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  jsu_pkg::bundle_t  res_i,
  output logic              res_ready_o,
  jsu_out_if.source         out_o
);
  import jsu_pkg::*;

  bundle_t    buf_q;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       is_last, take, load;

  assign is_last     = (({1'b0, idx_q} + 3'd1) == buf_q.count);
  assign take        = valid_q && out_o.ready;
  assign res_ready_o = !valid_q || (take && is_last);
  assign load        = res_valid_i && res_ready_o;

  // Index and occupancy
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take) begin
      if (is_last) valid_d = 1'b0;
      else idx_d = idx_q + 2'd1;
    end
    if (load) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) buf_q <= res_i;
  end

  // Result word
  assign out_o.valid      = valid_q;
  assign out_o.kind       = buf_q.kind;
  assign out_o.out_byte   = buf_q.bytes[idx_q];
  assign out_o.error_code = buf_q.err;
  assign out_o.last       = is_last;

endmodule

[tb/jsu_tb_pkg.sv]
// Testbench package for the JSON string unescaper: result record, hex helper, scoreboard class.
package jsu_tb_pkg;
  import jsu_pkg::*;

  // One result word as the block should present it
  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       last;
  } unescape_result_t;

  // Value of an ASCII hex digit, 16 when the byte is not one
  function automatic int unsigned nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return 16;
  endfunction

  // Tracks the parser state of the block and holds the words it should return
  class unescape_scoreboard;
    mode_e            mode;
    logic [1:0]       digits;
    logic [15:0]      accum;
    logic [9:0]       high_bits;
    unescape_result_t expected_q[$];
    int unsigned      mismatches;
    int unsigned      words_in;
    int unsigned      words_out;
    int unsigned      n_closed;
    int unsigned      n_errors;
    int unsigned      n_four_byte;

    function new();
      clear();
      mismatches  = 0;
      words_in    = 0;
      words_out   = 0;
      n_closed    = 0;
      n_errors    = 0;
      n_four_byte = 0;
    endfunction

    function void clear();
      mode      = MODE_WAIT;
      digits    = '0;
      accum     = '0;
      high_bits = '0;
    endfunction

    function void push(input kind_e k, input logic [7:0] d, input err_e e, input logic l);
      unescape_result_t r;
      r.kind = k;
      r.data = d;
      r.err  = e;
      r.last = l;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Any error drops the parser back to waiting for a quote
    function void fail_with(input err_e e);
      clear();
      push(KIND_ERROR, 8'h00, e, 1'b1);
    endfunction

    // UTF-8 bytes of one code point, last byte marked
    function void push_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
        push(KIND_DATA, cp[7:0], ERR_NONE, 1'b1);
      end else if (cp <= 21'h7FF) begin
        push(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE, 1'b0);
        push(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
      end else if (cp <= 21'hFFFF) begin
        push(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE, 1'b0);
        push(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
        push(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
      end else begin
        n_four_byte++;
        push(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE, 1'b0);
        push(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE, 1'b0);
        push(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
        push(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
      end
    endfunction

    // Accepted input word: advance the parser and queue what it yields
    function void note_word(input logic [7:0] b, input logic eoi);
      int unsigned d;
      logic [15:0] v;
      logic [7:0]  lit;
      words_in++;
      // text may end between strings without complaint
      if (eoi) begin
        if (mode != MODE_WAIT) fail_with(ERR_EARLY_END);
        return;
      end
      case (mode)
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            clear();
            push(KIND_CLOSED, 8'h00, ERR_NONE, 1'b1);
          end else if (b == CH_BSL) begin
            mode = MODE_ESC;
          end else begin
            push(KIND_DATA, b, ERR_NONE, 1'b1);
          end
        end
        MODE_ESC: begin
          case (b)
            CH_QUOTE, CH_BSL, CH_SLASH: lit = b;
            CH_B: lit = BYTE_BS;
            CH_F: lit = BYTE_FF;
            CH_N: lit = BYTE_LF;
            CH_R: lit = BYTE_CR;
            CH_T: lit = BYTE_HT;
            CH_U: begin
              mode   = MODE_HEX;
              digits = '0;
              accum  = '0;
              return;
            end
            default: begin
              fail_with(ERR_BAD_ESC);
              return;
            end
          endcase
          mode = MODE_STR;
          push(KIND_DATA, lit, ERR_NONE, 1'b1);
        end
        MODE_HEX, MODE_LOW_HEX: begin
          d = nibble_of(b);
          if (d > 15) begin
            fail_with(ERR_BAD_HEX);
            return;
          end
          accum = {accum[11:0], 4'(d)};
          if (digits < 2'd3) begin
            digits++;
            return;
          end
          v      = accum;
          digits = '0;
          accum  = '0;
          if (mode == MODE_HEX) begin
            // high surrogate waits for its partner
            if (v >= HIGH_SUR_LO && v <= HIGH_SUR_HI) begin
              high_bits = v[9:0];
              mode      = MODE_LOW_BSL;
              return;
            end
            mode = MODE_STR;
            push_utf8({5'b0, v});
          end else begin
            if (v < LOW_SUR_LO || v > LOW_SUR_HI) begin
              fail_with(ERR_BAD_LOW);
              return;
            end
            mode = MODE_STR;
            push_utf8(21'h10000 + {1'b0, high_bits, v[9:0]});
            high_bits = '0;
          end
        end
        MODE_LOW_BSL: begin
          if (b != CH_BSL) fail_with(ERR_NO_LOW);
          else mode = MODE_LOW_U;
        end
        MODE_LOW_U: begin
          if (b != CH_U) begin
            fail_with(ERR_NO_LOW);
          end else begin
            mode   = MODE_LOW_HEX;
            digits = '0;
            accum  = '0;
          end
        end
        default: begin
          if (b != CH_QUOTE) begin
            fail_with(ERR_NO_QUOTE);
          end else begin
            clear();
            mode = MODE_STR;
          end
        end
      endcase
    endfunction

    // Accepted result word: compare with the oldest expectation
    function void check_word(input logic [1:0] kind, input logic [7:0] data,
                             input logic [2:0] err, input logic last);
      unescape_result_t e;
      words_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind=%0d byte=%02h code=%0d last=%0b",
                 $time, kind, data, err, last);
        return;
      end
      e = expected_q.pop_front();
      if (e.kind == KIND_CLOSED) n_closed++;
      if (e.kind == KIND_ERROR) n_errors++;
      if (kind !== e.kind) begin
        mismatches++;
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
      end
      if (data !== e.data) begin
        mismatches++;
        $display("%0t: out_byte expected %02h actual %02h", $time, e.data, data);
      end
      if (err !== e.err) begin
        mismatches++;
        $display("%0t: error_code expected %0d actual %0d", $time, e.err, err);
      end
      if (last !== e.last) begin
        mismatches++;
        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

[tb/json_string_unescape_utf8_unit_test.sv]
// Top of the testbench for the JSON string unescaper: clock, reset, drivers, checker, watchdog.
module json_string_unescape_utf8_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;
  import jsu_tb_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_WORDS = 170;
  localparam int unsigned TAIL_CYCLES  = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_utf8_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  unescape_scoreboard sb = new();
  bit          no_gaps     = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("json_string_unescape_utf8_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stall before each word, then check it
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_word(out_if.kind, out_if.out_byte, out_if.error_code, out_if.last);
    end
  end

  // One input word, with a random gap ahead of it
  task automatic send_word(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(b, eoi);
    words_sent++;
  endtask

  // End of text; the byte lane carries junk
  task automatic send_eoi();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Hold off until every expected result is back; the input goes idle meanwhile
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] b);
    return b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_B || b == CH_F ||
           b == CH_N || b == CH_R || b == CH_T || b == CH_U;
  endfunction

  function automatic logic [7:0] simple_escape(input int unsigned idx);
    case (idx)
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return CH_SLASH;
      3:       return CH_B;
      4:       return CH_F;
      5:       return CH_N;
      6:       return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // \u and four hex digits in mixed case
  task automatic send_u(input logic [15:0] v);
    send_word(CH_BSL, 1'b0);
    send_word(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_word(hex_char(v[4*i +: 4]), 1'b0);
  endtask

  task automatic send_high();
    send_u(16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI)));
  endtask

  // One well-formed piece of string content
  task automatic send_element();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
        send_word(b, 1'b0);
      end
      3, 4: begin
        send_word(CH_BSL, 1'b0);
        send_word(simple_escape($urandom_range(0, 7)), 1'b0);
      end
      5: send_u(16'($urandom_range(0, 'h7F)));
      6: send_u(16'($urandom_range('h80, 'h7FF)));
      7: begin
        // half of these are lone low surrogates
        if ($urandom_range(0, 1)) send_u(16'($urandom_range(LOW_SUR_LO, LOW_SUR_HI)));
        else if ($urandom_range(0, 1)) send_u(16'($urandom_range('h800, 'hD7FF)));
        else send_u(16'($urandom_range('hE000, 'hFFFF)));
      end
      default: begin
        send_high();
        send_u(16'($urandom_range(LOW_SUR_LO, LOW_SUR_HI)));
      end
    endcase
  endtask

  // A broken piece that ends the string with an error
  task automatic send_fault();
    int unsigned what;
    int unsigned k;
    logic [7:0]  b;
    logic [15:0] v;
    what = $urandom_range(0, 5);
    case (what)
      0: begin
        send_word(CH_BSL, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        send_word(b, 1'b0);
      end
      1: begin
        send_word(CH_BSL, 1'b0);
        send_word(CH_U, 1'b0);
        k = $urandom_range(0, 3);
        repeat (k) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
        do b = 8'($urandom_range(0, 255)); while (nibble_of(b) < 16);
        send_word(b, 1'b0);
      end
      2: begin
        send_high();
        do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
        send_word(b, 1'b0);
      end
      3: begin
        send_high();
        send_word(CH_BSL, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
        send_word(b, 1'b0);
      end
      4: begin
        send_high();
        do v = 16'($urandom_range(0, 'hFFFF)); while (v >= LOW_SUR_LO && v <= LOW_SUR_HI);
        send_u(v);
      end
      default: begin
        // text runs out part way through an escape or plain content
        k = $urandom_range(0, 3);
        if (k == 1) send_word(CH_BSL, 1'b0);
        if (k == 2) begin
          send_word(CH_BSL, 1'b0);
          send_word(CH_U, 1'b0);
          repeat ($urandom_range(0, 3)) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
        end
        if (k == 3) send_high();
        send_eoi();
      end
    endcase
  endtask

  // Quote, a few pieces, then a closing quote or a fault
  task automatic send_string(input bit broken);
    int unsigned n_elems;
    int unsigned cut;
    n_elems = $urandom_range(0, 6);
    cut     = broken ? $urandom_range(0, n_elems) : n_elems + 1;
    send_word(CH_QUOTE, 1'b0);
    for (int unsigned i = 0; i < n_elems; i++) begin
      if (i == cut) begin
        send_fault();
        return;
      end
      send_element();
    end
    if (cut == n_elems) send_fault();
    else send_word(CH_QUOTE, 1'b0);
  endtask

  // Junk between strings
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_eoi();
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        send_word(b, 1'b0);
      end
    end
  endtask

  // Stimulus
  initial begin
    int unsigned start_count;
    int unsigned pick;
    int unsigned strings;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= 8'h00;
    in_if.end_of_input <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: end between strings, missing quote, raw extremes, escapes, largest pair, early end, bad escape
    send_eoi();
    send_word("x", 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(CH_BSL, 1'b0);
    send_word(CH_N, 1'b0);
    send_text("\\uDBFF\\udfff");
    send_eoi();
    send_text("\"\\q");
    drain();

    // random strings, gaps switched off now and then
    start_count = words_sent;
    strings     = 0;
    while (words_sent - start_count < RANDOM_WORDS) begin
      if (strings % 6 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) send_noise();
      else send_string(pick < 3);
      strings++;
      if (strings % 8 == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d input words through %0d results: %0d strings closed, %0d errors,",
             sb.words_in, sb.words_out, sb.n_closed, sb.n_errors);
    $display("%0d four-byte sequences, with random stalls on both channels.",
             sb.n_four_byte);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("json_string_unescape_utf8_unit_test OK");
    end else begin
      $display("json_string_unescape_utf8_unit_test NOT OK");
    end
    $finish;
  end

endmodule
